// ----- sv/tea_pkg.sv -----
// Shared constants, types and round functions for the TEA block cipher.
`default_nettype none

package tea_pkg;

  localparam int unsigned ROUNDS     = 8;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned CFG_IDX_W  = 8;

  localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam logic CMD_DECRYPT = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 8'd3;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t k0;
    word_t k1;
    word_t k2;
    word_t k3;
  } key_t;

  typedef struct packed {
    logic  cmd;
    word_t left;
    word_t right;
  } block_t;

  // Running sum after n additions of delta, modulo 2^32.
  function automatic word_t round_sum(input int unsigned n);
    logic [63:0] prod;
    prod = 64'(DELTA) * 64'(n);
    return prod[WORD_W-1:0];
  endfunction

  function automatic word_t mix(input word_t x, input word_t s,
                                input word_t ka, input word_t kb);
    return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
  endfunction

endpackage

`default_nettype wire

// ----- sv/tea_block_cipher_8_round.sv -----
// TEA block cipher, 8 rounds, one registered round per pipeline stage.
// Each block passes through the ROUNDS registered stages in order, one round per stage.
// Throughput: one block per cycle; each stage holds its item while the next is full.
// Reset clears all stage valid bits and the four key words to zero.
// Both ready outputs stay low while rst is high.
`default_nettype none

module tea_block_cipher_8_round (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire tea_pkg::word_t                 cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           command,
  input  wire tea_pkg::word_t                 block_left,
  input  wire tea_pkg::word_t                 block_right,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output tea_pkg::word_t                      out_left,
  output tea_pkg::word_t                      out_right
);
  import tea_pkg::*;

  key_t   key;
  logic   stage_valid [0:ROUNDS];
  logic   stage_ready [0:ROUNDS];
  block_t stage_data  [0:ROUNDS];

  tea_key_regs u_keys (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .key       (key)
  );

  assign stage_valid[0]      = in_valid;
  assign in_ready            = stage_ready[0] && !rst;
  assign stage_data[0].cmd   = command;
  assign stage_data[0].left  = block_left;
  assign stage_data[0].right = block_right;

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    localparam word_t SUM_ENC = round_sum(r + 1);
    localparam word_t SUM_DEC = round_sum(ROUNDS - r);

    tea_round u_round (
      .clk       (clk),
      .rst       (rst),
      .key       (key),
      .sum_enc   (SUM_ENC),
      .sum_dec   (SUM_DEC),
      .in_valid  (stage_valid[r]),
      .in_ready  (stage_ready[r]),
      .in_data   (stage_data[r]),
      .out_valid (stage_valid[r+1]),
      .out_ready (stage_ready[r+1]),
      .out_data  (stage_data[r+1])
    );
  end

  assign out_valid           = stage_valid[ROUNDS];
  assign stage_ready[ROUNDS] = out_ready;
  assign out_left            = stage_data[ROUNDS].left;
  assign out_right           = stage_data[ROUNDS].right;

endmodule

`default_nettype wire

// ----- sv/tea_key_regs.sv -----
// Key register file written through the configuration channel.
`default_nettype none

module tea_key_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire tea_pkg::word_t                 cfg_data,
  output tea_pkg::key_t                       key
);
  import tea_pkg::*;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_WORD0: key.k0 <= cfg_data;
        REG_KEY_WORD1: key.k1 <= cfg_data;
        REG_KEY_WORD2: key.k2 <= cfg_data;
        REG_KEY_WORD3: key.k3 <= cfg_data;
        default: ;  // drop writes beyond the key words
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/tea_round.sv -----
// One registered cipher round, encrypt or decrypt, with valid/ready flow control.
`default_nettype none

module tea_round (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire tea_pkg::key_t   key,
  input  wire tea_pkg::word_t  sum_enc,
  input  wire tea_pkg::word_t  sum_dec,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire tea_pkg::block_t in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output tea_pkg::block_t      out_data
);
  import tea_pkg::*;

  word_t  enc_left, enc_right;
  word_t  dec_left, dec_right;
  block_t data_next;

  always_comb begin
    enc_left  = in_data.left + mix(in_data.right, sum_enc, key.k0, key.k1);
    enc_right = in_data.right + mix(enc_left, sum_enc, key.k2, key.k3);
    dec_right = in_data.right - mix(in_data.left, sum_dec, key.k2, key.k3);
    dec_left  = in_data.left - mix(dec_right, sum_dec, key.k0, key.k1);

    data_next.cmd = in_data.cmd;
    if (in_data.cmd == CMD_DECRYPT) begin
      data_next.left  = dec_left;
      data_next.right = dec_right;
    end else begin
      data_next.left  = enc_left;
      data_next.right = enc_right;
    end
  end

  // Take a new item when this stage is empty or its item moves on.
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tea_block_cipher_8_round_checker.sv -----
// Checker for the TEA cipher: tracks the key, predicts each block and compares results.
`timescale 1ns / 100ps

module tea_block_cipher_8_round_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [tea_pkg::CFG_IDX_W-1:0] cfg_index,
  input  tea_pkg::word_t                cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          command,
  input  tea_pkg::word_t                block_left,
  input  tea_pkg::word_t                block_right,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  tea_pkg::word_t                out_left,
  input  tea_pkg::word_t                out_right,
  output int                            fail_count,
  output int                            pending
);
  import tea_pkg::*;

  typedef struct packed {
    word_t left;
    word_t right;
  } block_words_t;

  key_t         key_copy;
  block_words_t expected_blocks[$];
  int           mismatches = 0;

  // One Feistel half: shifted words plus key words, mixed with the running sum.
  function automatic word_t half_round(word_t x, word_t s, word_t ka, word_t kb);
    return ((x << 4) + ka) ^ (x + s) ^ ((x >> 5) + kb);
  endfunction

  function automatic block_words_t cipher_block(logic cmd, word_t left, word_t right,
                                                key_t k);
    word_t        y;
    word_t        z;
    word_t        sum;
    int           r;
    block_words_t res;
    y   = left;
    z   = right;
    sum = '0;
    if (cmd == CMD_ENCRYPT) begin
      for (r = 0; r < ROUNDS; r++) begin
        sum = sum + DELTA;
        y   = y + half_round(z, sum, k.k0, k.k1);
        z   = z + half_round(y, sum, k.k2, k.k3);
      end
    end else begin
      // start from delta times the round count, wrapped to 32 bits
      for (r = 0; r < ROUNDS; r++) sum = sum + DELTA;
      for (r = 0; r < ROUNDS; r++) begin
        z   = z - half_round(y, sum, k.k2, k.k3);
        y   = y - half_round(z, sum, k.k0, k.k1);
        sum = sum - DELTA;
      end
    end
    res.left  = y;
    res.right = z;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    block_words_t want;
    if (rst) begin
      key_copy = '0;
      expected_blocks.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_WORD0: key_copy.k0 = cfg_data;
          REG_KEY_WORD1: key_copy.k1 = cfg_data;
          REG_KEY_WORD2: key_copy.k2 = cfg_data;
          REG_KEY_WORD3: key_copy.k3 = cfg_data;
          default: ;
        endcase
      end
      // retire the oldest item before queueing a new one
      if (out_valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          $error("unexpected result: out_left %h out_right %h", out_left, out_right);
          mismatches++;
        end else begin
          want = expected_blocks.pop_front();
          if (out_left !== want.left) begin
            $error("out_left mismatch: expected %h, actual %h", want.left, out_left);
            mismatches++;
          end
          if (out_right !== want.right) begin
            $error("out_right mismatch: expected %h, actual %h", want.right, out_right);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_blocks.push_back(cipher_block(command, block_left, block_right, key_copy));
    end
    fail_count <= mismatches;
    pending    <= expected_blocks.size();
  end

endmodule

// ----- tb/tea_block_cipher_8_round_test.sv -----
// Testbench top for the TEA cipher: reset, key programming, block stimulus and verdict.
`timescale 1ns / 100ps

module tea_block_cipher_8_round_test;
  import tea_pkg::*;

  localparam int          RANDOM_PHASES  = 8;
  localparam int          PHASE_ITEMS    = 100;
  localparam int          LONG_HOLD      = 300;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int unsigned FIRST_UNUSED   = int'(REG_KEY_WORD3) + 1;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  word_t                cfg_data    = '0;
  logic                 in_valid    = 1'b0;
  logic                 in_ready;
  logic                 command     = CMD_ENCRYPT;
  word_t                block_left  = '0;
  word_t                block_right = '0;
  logic                 out_valid;
  logic                 out_ready   = 1'b0;
  word_t                out_left;
  word_t                out_right;

  int          fail_count;
  int          pending;
  int          quiet_cycles = 0;
  int          encrypt_sent = 0;
  int          decrypt_sent = 0;
  int          key_settings = 0;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_off_go  = 1'b0;

  tea_block_cipher_8_round dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .block_left (block_left),
    .block_right(block_right),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_left   (out_left),
    .out_right  (out_right)
  );

  tea_block_cipher_8_round_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .block_left (block_left),
    .block_right(block_right),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_left   (out_left),
    .out_right  (out_right),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
        (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $error("watchdog: no handshake for %0d cycles, %0d results outstanding",
             quiet_cycles, pending);
      $display("tea_block_cipher_8_round_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic word_t rand_word();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(0, WORD_W - 1);
      3:       return ~(word_t'(1) << $urandom_range(0, WORD_W - 1));
      default: return $urandom();
    endcase
  endfunction

  function automatic key_t pick_key();
    key_t k;
    case ($urandom_range(0, 3))
      0: k = '0;
      1: k = '1;
      2: k = {$urandom(), $urandom(), $urandom(), $urandom()};
      default: k = {rand_word(), rand_word(), rand_word(), rand_word()};
    endcase
    return k;
  endfunction

  // Leaves cfg_valid high so consecutive writes can go back to back.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, word_t data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_key(key_t k, bit add_stray);
    logic [CFG_IDX_W-1:0] stray_idx;
    stray_idx = CFG_IDX_W'($urandom_range(FIRST_UNUSED, (1 << CFG_IDX_W) - 1));
    write_reg(REG_KEY_WORD0, k.k0);
    write_reg(REG_KEY_WORD1, k.k1);
    // an unused index must leave the key alone
    if (add_stray) write_reg(stray_idx, $urandom());
    write_reg(REG_KEY_WORD2, k.k2);
    write_reg(REG_KEY_WORD3, k.k3);
    cfg_valid <= 1'b0;
    key_settings++;
  endtask

  // Offer one item and hold it until accepted; a nonzero gap then idles the input, a zero gap keeps in_valid high.
  task automatic send_block(logic cmd, word_t left, word_t right, int unsigned gap);
    in_valid    <= 1'b1;
    command     <= cmd;
    block_left  <= left;
    block_right <= right;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_ENCRYPT) encrypt_sent++;
    else decrypt_sent++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin : receiver
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_go) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_go = 1'b0;
      end else if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < rx_stall_pct) stall_left = pick_gap();
      end
    end
  end

  initial begin : stimulus
    int          phase;
    int          i;
    int unsigned gap;
    logic        cmd;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset key of all zeros, extreme blocks back to back
    send_block(CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 0);
    send_block(CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000, 0);
    send_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_block(CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_block(CMD_ENCRYPT, 32'h0000_0000, 32'hFFFF_FFFF, 0);
    send_block(CMD_DECRYPT, 32'hFFFF_FFFF, 32'h0000_0000, 0);
    send_block(CMD_ENCRYPT, 32'hAAAA_AAAA, 32'h5555_5555, 0);
    send_block(CMD_DECRYPT, 32'h5555_5555, 32'hAAAA_AAAA, 1);
    wait_drained();

    // all-ones key, with a write to an unused index in between
    program_key('1, 1'b1);
    send_block(CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000, 0);
    send_block(CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000, 0);
    send_block(CMD_ENCRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_block(CMD_DECRYPT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_block(CMD_ENCRYPT, 32'h8000_0000, 32'h0000_0001, 0);
    send_block(CMD_DECRYPT, 32'h0000_0001, 32'h8000_0000, 1);
    wait_drained();

    program_key({$urandom(), $urandom(), $urandom(), $urandom()}, 1'b0);
    for (i = 0; i < 4; i++)
      send_block(i[0] ? CMD_DECRYPT : CMD_ENCRYPT, $urandom(), $urandom(),
                 (i == 3) ? 1 : 0);

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      // hold off until the pipeline is empty before touching the key
      wait_drained();
      program_key(pick_key(), 1'($urandom_range(0, 1)));
      tx_idle_pct  = $urandom_range(5, 60);
      rx_stall_pct = $urandom_range(5, 60);
      if (phase == 1) begin
        // sender keeps pushing while the output is blocked
        tx_idle_pct = 0;
        hold_off_go = 1'b1;
      end else if (phase == 3) begin
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
      end
      for (i = 0; i < PHASE_ITEMS; i++) begin
        gap = ($urandom_range(0, 99) < tx_idle_pct) ? pick_gap() : 0;
        if (i == PHASE_ITEMS - 1 && gap == 0) gap = 1;
        cmd = 1'($urandom_range(0, 1));
        send_block(cmd, rand_word(), rand_word(), gap);
      end
    end

    wait_drained();
    repeat (ROUNDS + 4) @(posedge clk);
    $display("Run covered %0d encrypt and %0d decrypt blocks under %0d key settings,",
             encrypt_sent, decrypt_sent, key_settings + 1);
    $display("with random gaps, unused-index writes and a full-pipeline output hold-off.");
    if (fail_count == 0 && pending == 0) begin
      $display("tea_block_cipher_8_round_test passed");
    end else begin
      $display("tea_block_cipher_8_round_test failed");
    end
    $finish;
  end

endmodule
